/* rtl/mono_framebuffer_pixel_packer_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the mono frame buffer pixel packer
// Short forms for clocked implication checks, with reset as the disable term.
// ----------------------------------------------------------------------------
`ifndef MONO_FRAMEBUFFER_PIXEL_PACKER_TOP_MACROS_SVH
`define MONO_FRAMEBUFFER_PIXEL_PACKER_TOP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define MFPP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MFPP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/mfpp_pkg.sv */
// ----------------------------------------------------------------------------
// Mono frame buffer pixel packer package
// Field widths, operation codes, register indexes and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package mfpp_pkg;

   localparam int unsigned OP_W       = 2;
   localparam int unsigned COORD_W    = 9;
   localparam int unsigned DIM_W      = 10;
   localparam int unsigned INDEX_W    = 15;
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 10;

   localparam logic [OP_W-1:0] OP_SET_PIXEL = 2'd0;
   localparam logic [OP_W-1:0] OP_FILL      = 2'd1;
   localparam logic [OP_W-1:0] OP_READ      = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_LANDSCAPE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT    = 2'd2;

   localparam logic             LANDSCAPE_RST = 1'b1;
   localparam logic [DIM_W-1:0] WIDTH_RST     = 10'd400;
   localparam logic [DIM_W-1:0] HEIGHT_RST    = 10'd300;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_ACCESS,
      ST_FINISH,
      ST_FILL
   } state_type;

endpackage

`default_nettype wire

/* rtl/mfpp_if.sv */
// ----------------------------------------------------------------------------
// Mono frame buffer pixel packer channels
// Valid/ready channels for request words, response words and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface mfpp_req_if;
   logic                              valid;
   logic                              ready;
   logic [mfpp_pkg::OP_W-1:0]         op;
   logic [mfpp_pkg::COORD_W-1:0]      pixel_x;
   logic [mfpp_pkg::COORD_W-1:0]      pixel_y;
   logic                              pixel_on;
   logic [mfpp_pkg::BYTE_W-1:0]       fill_byte;
   logic [mfpp_pkg::INDEX_W-1:0]      byte_index;

   modport source (output valid, output op, output pixel_x, output pixel_y,
                   output pixel_on, output fill_byte, output byte_index,
                   input ready);
   modport sink (input valid, input op, input pixel_x, input pixel_y,
                 input pixel_on, input fill_byte, input byte_index,
                 output ready);
endinterface

interface mfpp_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [mfpp_pkg::BYTE_W-1:0]       read_byte;
   logic                              status;

   modport source (output valid, output read_byte, output status, input ready);
   modport sink (input valid, input read_byte, input status, output ready);
endinterface

interface mfpp_csr_if;
   logic                              valid;
   logic                              ready;
   logic [mfpp_pkg::CSR_IDX_W-1:0]    index;
   logic [mfpp_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/mono_framebuffer_pixel_packer_top.sv */
// Flow: a set-pixel or read word passes through the calculation, access and finish states, and
//   its response is registered from the finish state; no new request is taken until then.
// Fill writes one store byte per cycle in the fill state, then pushes its response from the finish state.
// The single store port, read then written back, sets the per-word cost.
// Reset: landscape mode, 400 x 300 frame, empty response; store contents are not cleared.
// ----------------------------------------------------------------------------
// Mono frame buffer pixel packer
// One-bit-per-pixel frame store with tiled byte packing, fill and byte readout.
// ----------------------------------------------------------------------------
`default_nettype none
`include "mono_framebuffer_pixel_packer_top_macros.svh"

module mono_framebuffer_pixel_packer_top #(
   parameter int unsigned FRAME_BYTES = 32768
) (
   input  logic        clock,
   input  logic        reset,
   mfpp_req_if.sink    req_ch,
   mfpp_rsp_if.source  rsp_ch,
   mfpp_csr_if.sink    csr_ch
);

   localparam int unsigned AW = $clog2(FRAME_BYTES);
   localparam logic [AW-1:0] LAST_ADDR = AW'(FRAME_BYTES - 1);

   mfpp_pkg::state_type state_ff, state_in;

   logic                             landscape_ff;
   logic [mfpp_pkg::DIM_W-1:0]       width_ff;
   logic [mfpp_pkg::DIM_W-1:0]       height_ff;

   logic [mfpp_pkg::OP_W-1:0]        op_ff;
   logic [mfpp_pkg::COORD_W-1:0]     x_ff;
   logic [mfpp_pkg::COORD_W-1:0]     y_ff;
   logic                             on_ff;
   logic [mfpp_pkg::BYTE_W-1:0]      fill_ff;
   logic [mfpp_pkg::INDEX_W-1:0]     bidx_ff;

   logic [AW-1:0]                    addr_ff, addr_in;
   logic [2:0]                       bit_ff, bit_in;
   logic                             bad_ff, bad_in;
   logic [mfpp_pkg::BYTE_W-1:0]      rdata_ff;
   logic [AW-1:0]                    fill_cnt_ff;

   logic                             rsp_valid_ff;
   logic [mfpp_pkg::BYTE_W-1:0]      rsp_byte_ff;
   logic                             rsp_status_ff;

   logic [mfpp_pkg::BYTE_W-1:0]      frame_mem [FRAME_BYTES];

   logic                             req_fire;
   logic                             push_ok;
   logic                             rsp_push;
   logic                             mem_we;
   logic [AW-1:0]                    mem_addr;
   logic [mfpp_pkg::BYTE_W-1:0]      mem_wdata;
   logic [mfpp_pkg::BYTE_W-1:0]      bit_mask;
   logic                             fill_last;

   // Address calculation terms.
   logic [mfpp_pkg::DIM_W-1:0]       flip_y;
   logic                             in_frame;
   logic [7:0]                       major;
   logic [7:0]                       tiles;
   logic [7:0]                       minor;
   logic [2:0]                       bit_sel;
   logic [15:0]                      tile_prod;
   logic [16:0]                      pix_addr;
   logic [31:0]                      calc_addr;

   assign req_fire  = req_ch.valid && req_ch.ready;
   assign push_ok   = !rsp_valid_ff || rsp_ch.ready;
   assign fill_last = (fill_cnt_ff == LAST_ADDR);

   assign req_ch.ready     = (state_ff == mfpp_pkg::ST_IDLE);
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.read_byte = rsp_byte_ff;
   assign rsp_ch.status    = rsp_status_ff;
   assign csr_ch.ready     = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         landscape_ff <= mfpp_pkg::LANDSCAPE_RST;
         width_ff     <= mfpp_pkg::WIDTH_RST;
         height_ff    <= mfpp_pkg::HEIGHT_RST;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            mfpp_pkg::CSR_LANDSCAPE: landscape_ff <= csr_ch.data[0];
            mfpp_pkg::CSR_WIDTH:     width_ff     <= csr_ch.data;
            mfpp_pkg::CSR_HEIGHT:    height_ff    <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // Captured request word.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff   <= req_ch.op;
         x_ff    <= req_ch.pixel_x;
         y_ff    <= req_ch.pixel_y;
         on_ff   <= req_ch.pixel_on;
         fill_ff <= req_ch.fill_byte;
         bidx_ff <= req_ch.byte_index;
      end
   end

   // Tile address: the y flip is only meaningful once y is known to be inside the frame.
   always_comb begin
      flip_y   = height_ff - 10'd1 - {1'b0, y_ff};
      in_frame = ({1'b0, x_ff} < width_ff) && ({1'b0, y_ff} < height_ff);
      if (landscape_ff) begin
         major   = x_ff[8:1];
         tiles   = height_ff[9:2];
         minor   = flip_y[9:2];
         bit_sel = {flip_y[1:0], x_ff[0]};
      end else begin
         major   = y_ff[8:1];
         tiles   = width_ff[9:2];
         minor   = {1'b0, x_ff[8:2]};
         bit_sel = {x_ff[1:0], y_ff[0]};
      end
      tile_prod = {8'b0, major} * {8'b0, tiles};
      pix_addr  = {1'b0, tile_prod} + {9'b0, minor};
      bit_in    = 3'd7 - bit_sel;
      case (op_ff)
         mfpp_pkg::OP_SET_PIXEL: begin
            calc_addr = {15'b0, pix_addr};
            bad_in    = !in_frame || (calc_addr >= FRAME_BYTES);
         end
         mfpp_pkg::OP_READ: begin
            calc_addr = {17'b0, bidx_ff};
            bad_in    = (calc_addr >= FRAME_BYTES);
         end
         mfpp_pkg::OP_FILL: begin
            calc_addr = 32'd0;
            bad_in    = 1'b0;
         end
         default: begin
            calc_addr = 32'd0;
            bad_in    = 1'b1;
         end
      endcase
      addr_in = calc_addr[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (state_ff == mfpp_pkg::ST_CALC) begin
         addr_ff <= addr_in;
         bit_ff  <= bit_in;
         bad_ff  <= bad_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mfpp_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = mfpp_pkg::ST_CALC;
            end
         end
         mfpp_pkg::ST_CALC: begin
            if (op_ff == mfpp_pkg::OP_FILL) begin
               state_in = mfpp_pkg::ST_FILL;
            end else begin
               state_in = mfpp_pkg::ST_ACCESS;
            end
         end
         mfpp_pkg::ST_ACCESS: state_in = mfpp_pkg::ST_FINISH;
         mfpp_pkg::ST_FILL: begin
            if (fill_last) begin
               state_in = mfpp_pkg::ST_FINISH;
            end
         end
         mfpp_pkg::ST_FINISH: begin
            if (push_ok) begin
               state_in = mfpp_pkg::ST_IDLE;
            end
         end
         default: state_in = mfpp_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mfpp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Store port control and write-back data.
   always_comb begin
      bit_mask  = 8'd1 << bit_ff;
      mem_we    = 1'b0;
      mem_addr  = addr_ff;
      mem_wdata = on_ff ? (rdata_ff | bit_mask) : (rdata_ff & ~bit_mask);
      rsp_push  = 1'b0;
      case (state_ff)
         mfpp_pkg::ST_FILL: begin
            mem_we    = 1'b1;
            mem_addr  = fill_cnt_ff;
            mem_wdata = fill_ff;
         end
         mfpp_pkg::ST_FINISH: begin
            rsp_push = push_ok;
            mem_we   = push_ok && (op_ff == mfpp_pkg::OP_SET_PIXEL) && !bad_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[mem_addr] <= mem_wdata;
      end
      if (state_ff == mfpp_pkg::ST_ACCESS) begin
         rdata_ff <= frame_mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == mfpp_pkg::ST_CALC) begin
         fill_cnt_ff <= '0;
      end else if (state_ff == mfpp_pkg::ST_FILL) begin
         fill_cnt_ff <= fill_cnt_ff + AW'(1);
      end
   end

   // Response register; it parts the response side from the request side.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_push) begin
         rsp_byte_ff   <= ((op_ff == mfpp_pkg::OP_READ) && !bad_ff) ? rdata_ff : 8'd0;
         rsp_status_ff <= bad_ff;
      end
   end

   `MFPP_ASSERT_SAME(a_write_state, clock, reset, mem_we,
      (state_ff == mfpp_pkg::ST_FILL) || (state_ff == mfpp_pkg::ST_FINISH),
      "store written outside fill or write-back")
   `MFPP_ASSERT_NEXT(a_accept_calc, clock, reset, req_fire,
      state_ff == mfpp_pkg::ST_CALC,
      "accepted word did not enter address calculation")
   `MFPP_ASSERT_NEXT(a_push_valid, clock, reset, rsp_push, rsp_valid_ff,
      "pushed response not presented")
   `MFPP_ASSERT_SAME(a_one_bit, clock, reset,
      mem_we && (state_ff == mfpp_pkg::ST_FINISH),
      $countones(mem_wdata ^ rdata_ff) <= 1,
      "pixel write changed more than one bit")
   `MFPP_ASSERT_NEXT(a_fill_end, clock, reset,
      (state_ff == mfpp_pkg::ST_FILL) && fill_last,
      state_ff == mfpp_pkg::ST_FINISH,
      "fill did not finish after last byte")

endmodule

`default_nettype wire
